// ===== src/mtkd_pkg.sv =====
// shared types, constants and key tables for the multi-tap keypad decoder
package mtkd_pkg;

  localparam logic [3:0] NUM_KEYS   = 4'd10;
  localparam logic [3:0] KEY_SPACE  = 4'd10;
  localparam logic [3:0] RUN_MAX    = 4'd15;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [3:0] pending_key;
    logic [3:0] run_length;
  } run_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] ch0;
    logic [7:0] ch1;
  } step_res_t;

  // number of characters on a key
  function automatic logic [3:0] key_len(input logic [3:0] key);
    logic [3:0] len;
    unique case (key)
      4'd5, 4'd7: len = 4'd5;
      4'd8:       len = 4'd9;
      4'd9:       len = 4'd1;
      default:    len = 4'd4;
    endcase
    return len;
  endfunction

  // character at a position of a key's string
  function automatic logic [7:0] key_char(input logic [3:0] key, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (key)
      4'd0: begin
        unique case (pos)
          4'd0: c = "0"; 4'd1: c = "a"; 4'd2: c = "b"; 4'd3: c = "c";
          default: c = 8'h00;
        endcase
      end
      4'd1: begin
        unique case (pos)
          4'd0: c = "1"; 4'd1: c = "d"; 4'd2: c = "e"; 4'd3: c = "f";
          default: c = 8'h00;
        endcase
      end
      4'd2: begin
        unique case (pos)
          4'd0: c = "2"; 4'd1: c = "g"; 4'd2: c = "h"; 4'd3: c = "i";
          default: c = 8'h00;
        endcase
      end
      4'd3: begin
        unique case (pos)
          4'd0: c = "3"; 4'd1: c = "j"; 4'd2: c = "k"; 4'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      4'd4: begin
        unique case (pos)
          4'd0: c = "4"; 4'd1: c = "m"; 4'd2: c = "n"; 4'd3: c = "o";
          default: c = 8'h00;
        endcase
      end
      4'd5: begin
        unique case (pos)
          4'd0: c = "5"; 4'd1: c = "p"; 4'd2: c = "q"; 4'd3: c = "r"; 4'd4: c = "s";
          default: c = 8'h00;
        endcase
      end
      4'd6: begin
        unique case (pos)
          4'd0: c = "6"; 4'd1: c = "t"; 4'd2: c = "u"; 4'd3: c = "v";
          default: c = 8'h00;
        endcase
      end
      4'd7: begin
        unique case (pos)
          4'd0: c = "7"; 4'd1: c = "w"; 4'd2: c = "x"; 4'd3: c = "y"; 4'd4: c = "z";
          default: c = 8'h00;
        endcase
      end
      4'd8: begin
        unique case (pos)
          4'd0: c = "8"; 4'd1: c = " "; 4'd2: c = "."; 4'd3: c = ",";
          4'd4: c = "@"; 4'd5: c = "*"; 4'd6: c = "="; 4'd7: c = "+";
          4'd8: c = "-";
          default: c = 8'h00;
        endcase
      end
      4'd9: begin
        unique case (pos)
          4'd0: c = "9";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // a pending run yields a character when it ends, if its length does not exceed the key's string
  function automatic logic flush_ok(input run_state_t s);
    return (s.run_length != 4'd0) && (s.pending_key < NUM_KEYS) &&
           (s.run_length <= key_len(s.pending_key));
  endfunction

  function automatic logic [7:0] flush_ch(input run_state_t s);
    return key_char(s.pending_key, s.run_length - 4'd1);
  endfunction

endpackage

// ===== src/mtkd_step.sv =====
// combinational decode of one key request against the pending run
module mtkd_step
  import mtkd_pkg::*;
(
  input  logic [3:0] key,
  input  logic       eos,
  input  run_state_t cur,
  output run_state_t nxt,
  output step_res_t  res
);

  run_state_t mid;
  run_state_t clr;
  logic       e1;
  logic       e2;
  logic [7:0] c1;
  logic [7:0] c2;

  assign clr = '{pending_key: 4'd0, run_length: 4'd0};

  always_comb begin
    e1  = 1'b0;
    e2  = 1'b0;
    c1  = flush_ch(cur);
    c2  = 8'h00;
    mid = cur;
    nxt = cur;
    priority if (key < NUM_KEYS) begin
      if (cur.run_length != 4'd0 && cur.pending_key == key) begin
        mid.pending_key = cur.pending_key;
        mid.run_length  = (cur.run_length < RUN_MAX) ? cur.run_length + 4'd1 : cur.run_length;
      end else begin
        e1  = flush_ok(cur);
        mid = '{pending_key: key, run_length: 4'd1};
      end
      if (eos) begin
        e2  = flush_ok(mid);
        c2  = flush_ch(mid);
        nxt = clr;
      end else begin
        nxt = mid;
      end
    end else if (key == KEY_SPACE) begin
      e1  = flush_ok(cur);
      e2  = 1'b1;
      c2  = CHAR_SPACE;
      nxt = clr;
    end else begin
      if (eos) begin
        e2  = flush_ok(cur);
        c2  = flush_ch(cur);
        nxt = clr;
      end
    end
  end

  // pack emitted characters in order
  always_comb begin
    res.cnt = 2'd0;
    res.ch0 = c1;
    res.ch1 = c2;
    if (e1) begin
      res.cnt = e2 ? 2'd2 : 2'd1;
    end else if (e2) begin
      res.cnt = 2'd1;
      res.ch0 = c2;
    end
  end

endmodule

// ===== src/mtkd_obuf.sv =====
// two-slot result register draining one character per cycle while out_tready is high
module mtkd_obuf
  import mtkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  step_res_t  res,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [7:0] ch0_r;
  logic [7:0] ch0_nxt;
  logic [7:0] ch1_r;
  logic [7:0] ch1_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign can_load   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = ch0_r;
  assign out_tlast  = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    ch0_nxt = ch0_r;
    ch1_nxt = ch1_r;
    if (load) begin
      cnt_nxt = res.cnt;
      ch0_nxt = res.ch0;
      ch1_nxt = res.ch1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      ch0_nxt = ch1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch0_r <= ch0_nxt;
    ch1_r <= ch1_nxt;
  end

endmodule

// ===== src/multitap_keypad_decoder.sv =====
// multi-tap keypad decoder top level: input register, run state, result buffer
// path: a request is held in the input register until the result buffer can load its characters
// throughput: one request per cycle while out_tready is high; a request yielding two characters
//   holds off the next one, set by the single output port draining the two-slot result register
// reset: synchronous active-low rst_n clears the input stage, the pending run
//   and the result buffer
module multitap_keypad_decoder
  import mtkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] key_code, [7:4] zero
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic       out_tlast
);

  logic       vld_r;
  logic       vld_nxt;
  logic [3:0] key_r;
  logic       eos_r;
  run_state_t st_r;
  run_state_t st_nxt;
  step_res_t  res;
  logic       can_load;
  logic       adv;
  logic       acc;

  assign adv       = vld_r && can_load;
  assign in_tready = !vld_r || can_load;
  assign acc       = in_tvalid && in_tready;

  mtkd_step u_step (
    .key (key_r),
    .eos (eos_r),
    .cur (st_r),
    .nxt (st_nxt),
    .res (res)
  );

  mtkd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      st_r  <= '{pending_key: 4'd0, run_length: 4'd0};
    end else begin
      vld_r <= vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      key_r <= in_tdata[3:0];
      eos_r <= in_tlast;
    end
  end

endmodule
